// ----- hw/rtl/vrbs_pkg.sv -----
package vrbs_pkg;

	localparam int FUNC_W     = 3;
	localparam int DIGIT_W    = 4;
	localparam int BRIGHT_W   = 4;
	localparam int PERIOD_W   = 16;
	localparam int SLEN_W     = 5;
	localparam int FLASH_W    = 8;
	localparam int PWM_W      = 8;
	localparam int BLINK_W    = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int TICKS_PER_MS_DEF     = 4;
	localparam int POLL_MS_DEF          = 18;
	localparam int MAX_SCROLL_CHARS_DEF = 25;

	localparam logic [DIGIT_W-1:0]  TICK_DIV_RST  = 4'd8;
	localparam logic [DIGIT_W-1:0]  SLOTS_RST     = 4'd8;
	localparam logic [BRIGHT_W-1:0] BRIGHT_RST    = 4'd10;
	localparam logic [PERIOD_W-1:0] PERIOD_RST    = 16'd300;
	localparam logic [BRIGHT_W-1:0] BRIGHT_MAX    = 4'd10;
	localparam logic [PWM_W-1:0]    BRIGHT_STEP   = 8'd25;

	localparam logic [PWM_W-1:0]    PWM_DIM       = 8'd185;
	localparam logic [PWM_W-1:0]    PWM_OFF       = 8'd255;
	localparam logic [BLINK_W-1:0]  BLINK_SLOW    = 10'd1000;
	localparam logic [BLINK_W-1:0]  BLINK_FAST_ON = 10'd550;
	localparam logic [BLINK_W-1:0]  BLINK_FAST_OFF = 10'd450;

	typedef enum logic [FUNC_W-1:0] {
		FN_TICK   = 3'd0,
		FN_BLINK  = 3'd1,
		FN_SCROLL = 3'd2,
		FN_STOP   = 3'd3,
		FN_FLASH  = 3'd4
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TICK_DIV = 2'd0,
		CFG_SLOTS    = 2'd1,
		CFG_BRIGHT   = 2'd2,
		CFG_PERIOD   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic               blink_enable;
		logic               alarming;
		logic [SLEN_W-1:0]  scroll_length;
		logic [FLASH_W-1:0] flash_ms;
		logic               mark_received;
		logic               display_enable;
	} item_t;

	typedef struct packed {
		logic               digit_strobe;
		logic [DIGIT_W-1:0] digit_index;
		logic               ms_pulse;
		logic               poll_pulse;
		logic [PWM_W-1:0]   pwm_compare;
		logic               blink_lit;
		logic [SLEN_W-1:0]  scroll_position;
		logic               scroll_active;
		logic               flash_active;
		logic               received_mark;
	} res_t;

	typedef struct packed {
		logic [DIGIT_W-1:0]  tick_divider;
		logic [DIGIT_W-1:0]  digit_slots;
		logic [BRIGHT_W-1:0] brightness;
		logic [PERIOD_W-1:0] scroll_period;
		logic                bright_wr;
	} cfg_t;

	function automatic logic [PWM_W-1:0] bright_compare(input logic [BRIGHT_W-1:0] b);
		logic [BRIGHT_W-1:0] bs;
		bs = (b > BRIGHT_MAX) ? BRIGHT_MAX : b;
		return PWM_W'(BRIGHT_MAX - bs) * BRIGHT_STEP;
	endfunction

endpackage

// ----- hw/rtl/vrbs_item_if.sv -----
interface vrbs_item_if;
	logic                         valid;
	logic                         ready;
	logic [vrbs_pkg::FUNC_W-1:0]  func;
	logic                         blink_enable;
	logic                         alarming;
	logic [vrbs_pkg::SLEN_W-1:0]  scroll_length;
	logic [vrbs_pkg::FLASH_W-1:0] flash_ms;
	logic                         mark_received;
	logic                         display_enable;

	modport source (output valid, func, blink_enable, alarming, scroll_length, flash_ms,
		mark_received, display_enable, input ready);
	modport sink (input valid, func, blink_enable, alarming, scroll_length, flash_ms,
		mark_received, display_enable, output ready);
endinterface

// ----- hw/rtl/vrbs_result_if.sv -----
interface vrbs_result_if;
	logic                         valid;
	logic                         ready;
	logic                         digit_strobe;
	logic [vrbs_pkg::DIGIT_W-1:0] digit_index;
	logic                         ms_pulse;
	logic                         poll_pulse;
	logic [vrbs_pkg::PWM_W-1:0]   pwm_compare;
	logic                         blink_lit;
	logic [vrbs_pkg::SLEN_W-1:0]  scroll_position;
	logic                         scroll_active;
	logic                         flash_active;
	logic                         received_mark;

	modport source (output valid, digit_strobe, digit_index, ms_pulse, poll_pulse,
		pwm_compare, blink_lit, scroll_position, scroll_active, flash_active,
		received_mark, input ready);
	modport sink (input valid, digit_strobe, digit_index, ms_pulse, poll_pulse,
		pwm_compare, blink_lit, scroll_position, scroll_active, flash_active,
		received_mark, output ready);
endinterface

// ----- hw/rtl/vfd_refresh_blink_scroll_timer_top.sv -----
// channel  | dir | handshake     | word
// item     | in  | valid / ready | func, blink_enable, alarming, scroll_length, flash_ms,
//          |     |               | mark_received, display_enable
// result   | out | valid / ready | digit_strobe, digit_index, ms_pulse, poll_pulse,
//          |     |               | pwm_compare, blink_lit, scroll_position, scroll_active,
//          |     |               | flash_active, received_mark
// cfg      | in  | cfg_we        | cfg_idx, cfg_wdata
//
// one word per cycle unless the result stalls; a result is valid once its word has passed
// the input register, then the state update into the result register
// arst_n clears all timer state and loads the register reset values
// a stalled result holds the input register; item.ready drops only when both are full
module vfd_refresh_blink_scroll_timer_top #(
	parameter int TICKS_PER_MS     = vrbs_pkg::TICKS_PER_MS_DEF,
	parameter int POLL_MS          = vrbs_pkg::POLL_MS_DEF,
	parameter int MAX_SCROLL_CHARS = vrbs_pkg::MAX_SCROLL_CHARS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [vrbs_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [vrbs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	vrbs_item_if.sink                       item,
	vrbs_result_if.source                   result
);
	import vrbs_pkg::*;

	item_t it_s1;
	logic  valid_s1;
	res_t  res_next, res_s2;
	logic  valid_s2;
	logic  out_free, adv;
	cfg_t  cfg;

	assign out_free   = !valid_s2 || result.ready;
	assign adv        = valid_s1 && out_free;
	assign item.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			it_s1.func           <= item.func;
			it_s1.blink_enable   <= item.blink_enable;
			it_s1.alarming       <= item.alarming;
			it_s1.scroll_length  <= item.scroll_length;
			it_s1.flash_ms       <= item.flash_ms;
			it_s1.mark_received  <= item.mark_received;
			it_s1.display_enable <= item.display_enable;
		end
	end

	vrbs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	vrbs_core #(
		.TICKS_PER_MS     (TICKS_PER_MS),
		.POLL_MS          (POLL_MS),
		.MAX_SCROLL_CHARS (MAX_SCROLL_CHARS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.it     (it_s1),
		.cfg    (cfg),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_next;
		end
	end

	assign result.valid           = valid_s2;
	assign result.digit_strobe    = res_s2.digit_strobe;
	assign result.digit_index     = res_s2.digit_index;
	assign result.ms_pulse        = res_s2.ms_pulse;
	assign result.poll_pulse      = res_s2.poll_pulse;
	assign result.pwm_compare     = res_s2.pwm_compare;
	assign result.blink_lit       = res_s2.blink_lit;
	assign result.scroll_position = res_s2.scroll_position;
	assign result.scroll_active   = res_s2.scroll_active;
	assign result.flash_active    = res_s2.flash_active;
	assign result.received_mark   = res_s2.received_mark;

endmodule

// ----- hw/rtl/vrbs_cfg.sv -----
module vrbs_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [vrbs_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [vrbs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output vrbs_pkg::cfg_t                    cfg
);
	import vrbs_pkg::*;

	logic [DIGIT_W-1:0]  tick_div_q;
	logic [DIGIT_W-1:0]  slots_q;
	logic [BRIGHT_W-1:0] bright_q;
	logic [PERIOD_W-1:0] period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_div_q <= TICK_DIV_RST;
			slots_q    <= SLOTS_RST;
			bright_q   <= BRIGHT_RST;
			period_q   <= PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_TICK_DIV: tick_div_q <= cfg_wdata[DIGIT_W-1:0];
				CFG_SLOTS:    slots_q    <= cfg_wdata[DIGIT_W-1:0];
				CFG_BRIGHT:   bright_q   <= cfg_wdata[BRIGHT_W-1:0];
				CFG_PERIOD:   period_q   <= cfg_wdata[PERIOD_W-1:0];
			endcase
		end
	end

	always_comb begin
		cfg.tick_divider  = tick_div_q;
		cfg.digit_slots   = slots_q;
		cfg.brightness    = bright_q;
		cfg.scroll_period = period_q;
		cfg.bright_wr     = cfg_we && (cfg_idx_t'(cfg_idx) == CFG_BRIGHT);
	end

endmodule

// ----- hw/rtl/vrbs_core.sv -----
module vrbs_core #(
	parameter int TICKS_PER_MS     = vrbs_pkg::TICKS_PER_MS_DEF,
	parameter int POLL_MS          = vrbs_pkg::POLL_MS_DEF,
	parameter int MAX_SCROLL_CHARS = vrbs_pkg::MAX_SCROLL_CHARS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  vrbs_pkg::item_t it,
	input  vrbs_pkg::cfg_t  cfg,
	output vrbs_pkg::res_t  res
);
	import vrbs_pkg::*;

	localparam int PS_W = (TICKS_PER_MS > 1) ? $clog2(TICKS_PER_MS) : 1;
	localparam int PL_W = (POLL_MS > 1) ? $clog2(POLL_MS) : 1;
	localparam logic [PS_W-1:0]   PS_LAST    = PS_W'(TICKS_PER_MS - 1);
	localparam logic [PL_W-1:0]   PL_LAST    = PL_W'(POLL_MS - 1);
	localparam logic [SLEN_W-1:0] SCROLL_CAP = SLEN_W'(MAX_SCROLL_CHARS + 1);

	logic [DIGIT_W-1:0]  tick_q, tick_n, tick_inc;
	logic [DIGIT_W-1:0]  digit_q, digit_n, digit_inc;
	logic [PS_W-1:0]     ps_q, ps_n;
	logic                active_q, active_n;
	logic                lit_q, lit_n;
	logic                slow_q, slow_n;
	logic                dim_q, dim_n;
	logic                off_q, off_n;
	logic [BLINK_W-1:0]  bcnt_q, bcnt_n, bcnt_inc, blimit;
	logic [PL_W-1:0]     poll_q, poll_n;
	logic [FLASH_W-1:0]  flash_q, flash_n;
	logic                recv_q, recv_n;
	logic                son_q, son_n;
	logic [SLEN_W-1:0]   soff_q, soff_n, soff_inc;
	logic [PERIOD_W-1:0] swait_q, swait_n;
	logic [SLEN_W-1:0]   send_q, send_n;
	logic                strobe, msp, poll;
	logic [DIGIT_W-1:0]  idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			digit_q  <= '0;
			ps_q     <= '0;
			active_q <= 1'b0;
			lit_q    <= 1'b0;
			slow_q   <= 1'b0;
			dim_q    <= 1'b0;
			off_q    <= 1'b0;
			bcnt_q   <= '0;
			poll_q   <= '0;
			flash_q  <= '0;
			recv_q   <= 1'b0;
			son_q    <= 1'b0;
			soff_q   <= '0;
			swait_q  <= '0;
			send_q   <= '0;
		end else begin
			tick_q   <= tick_n;
			digit_q  <= digit_n;
			ps_q     <= ps_n;
			active_q <= active_n;
			lit_q    <= lit_n;
			slow_q   <= slow_n;
			dim_q    <= dim_n;
			off_q    <= off_n;
			bcnt_q   <= bcnt_n;
			poll_q   <= poll_n;
			flash_q  <= flash_n;
			recv_q   <= recv_n;
			son_q    <= son_n;
			soff_q   <= soff_n;
			swait_q  <= swait_n;
			send_q   <= send_n;
		end
	end

	always_comb begin
		tick_n   = tick_q;
		digit_n  = digit_q;
		ps_n     = ps_q;
		active_n = active_q;
		lit_n    = lit_q;
		slow_n   = slow_q;
		dim_n    = dim_q;
		off_n    = off_q;
		bcnt_n   = bcnt_q;
		poll_n   = poll_q;
		flash_n  = flash_q;
		recv_n   = recv_q;
		son_n    = son_q;
		soff_n   = soff_q;
		swait_n  = swait_q;
		send_n   = send_q;
		strobe   = 1'b0;
		msp      = 1'b0;
		poll     = 1'b0;
		idx      = '0;
		tick_inc  = tick_q + 1'b1;
		digit_inc = digit_q + 1'b1;
		bcnt_inc  = bcnt_q + 1'b1;
		soff_inc  = soff_q + 1'b1;
		blimit    = slow_q ? BLINK_SLOW : (lit_q ? BLINK_FAST_ON : BLINK_FAST_OFF);

		if (en) begin
			unique case (func_t'(it.func))
				FN_TICK: begin
					if (tick_inc == cfg.tick_divider) begin
						tick_n = '0;
						if (it.display_enable) begin
							strobe  = 1'b1;
							idx     = digit_q;
							digit_n = (digit_inc == cfg.digit_slots) ? '0 : digit_inc;
						end
					end else begin
						tick_n = tick_inc;
					end
					if (ps_q == PS_LAST) begin
						ps_n = '0;
						msp  = 1'b1;
						// blink generator
						if (active_q) begin
							if (bcnt_inc >= blimit) begin
								bcnt_n = '0;
								lit_n  = !lit_q;
								off_n  = lit_q;
								if (lit_q) begin
									dim_n = it.alarming;
								end
							end else begin
								bcnt_n = bcnt_inc;
							end
						end
						// button poll
						if (poll_q == PL_LAST) begin
							poll_n = '0;
							poll   = 1'b1;
						end else begin
							poll_n = poll_q + 1'b1;
						end
						// flash countdown
						if (flash_q != '0) begin
							flash_n = flash_q - 1'b1;
							if (flash_q == FLASH_W'(1)) begin
								recv_n = 1'b0;
							end
						end
						// scroll stepper
						if (son_q) begin
							if (swait_q != '0) begin
								swait_n = swait_q - 1'b1;
							end else begin
								soff_n  = soff_inc;
								swait_n = cfg.scroll_period;
								if (soff_inc >= send_q) begin
									son_n = 1'b0;
								end
							end
						end
					end else begin
						ps_n = ps_q + 1'b1;
					end
				end
				FN_BLINK: begin
					active_n = it.blink_enable;
					slow_n   = it.alarming;
					if (!it.blink_enable) begin
						lit_n = 1'b1;
						off_n = 1'b0;
					end
				end
				FN_SCROLL: begin
					send_n  = (it.scroll_length > SCROLL_CAP) ? SCROLL_CAP : it.scroll_length;
					soff_n  = '0;
					swait_n = cfg.scroll_period;
					son_n   = 1'b1;
				end
				FN_STOP: begin
					son_n = 1'b0;
				end
				FN_FLASH: begin
					flash_n = it.flash_ms;
					if (it.mark_received) begin
						recv_n = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end

		if (cfg.bright_wr) begin
			off_n = 1'b0;
		end

		res.digit_strobe    = strobe;
		res.digit_index     = idx;
		res.ms_pulse        = msp;
		res.poll_pulse      = poll;
		res.pwm_compare     = off_n ? (dim_n ? PWM_DIM : PWM_OFF) : bright_compare(cfg.brightness);
		res.blink_lit       = lit_n;
		res.scroll_position = soff_n;
		res.scroll_active   = son_n;
		res.flash_active    = (flash_n != '0);
		res.received_mark   = recv_n;
	end

endmodule
